>>> design/adc_conversion_request_queue_assert.svh
// Assertion macros shared by the conversion request queue modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ADC_CONVERSION_REQUEST_QUEUE_ASSERT_SVH
`define ADC_CONVERSION_REQUEST_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted.
`define ACRQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("acrq assertion failed");

// Clocked check that also holds during reset.
`define ACRQ_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("acrq assertion failed");

`else

`define ACRQ_ASSERT(label, clk, rst_n, prop)
`define ACRQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> design/acrq_pkg.sv
// Package of the conversion request queue: sizes, codes, payload types
// and the control interface between controller and datapath. No dependencies.
package acrq_pkg;

	// Sizes.
	localparam int SLOTS  = 8;
	localparam int SLOT_W = 3;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int CHAN_W = 5;
	localparam int MUX_W  = 4;
	localparam int VAL_W  = 16;

	// Command codes of a request.
	typedef enum logic {
		CMD_ENQUEUE  = 1'b0,
		CMD_COMPLETE = 1'b1
	} cmd_t;

	// Per-slot status.
	typedef enum logic [1:0] {
		SLOT_IDLE       = 2'd0,
		SLOT_ENQUEUED   = 2'd1,
		SLOT_CONVERTING = 2'd2
	} slot_state_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_LOOKUP,
		S_START,
		S_OUT
	} ctrl_state_t;

	// Input request.
	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] request_slot;
		logic [CHAN_W-1:0] channel_code;
		logic [VAL_W-1:0]  conversion_value;
	} req_t;

	// Result.
	typedef struct packed {
		logic              enqueue_accepted;
		logic              start_conversion;
		logic [MUX_W-1:0]  start_mux_position;
		logic              start_input_mode;
		logic              done_valid;
		logic [SLOT_W-1:0] done_slot;
		logic [VAL_W-1:0]  done_value;
	} rsp_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic start;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic chain;
	} dp_stat_t;

	// Mux position is the low part of a channel code.
	function automatic logic [MUX_W-1:0] mux_of(input logic [CHAN_W-1:0] chan);
		return chan[MUX_W-1:0];
	endfunction

	// Input mode is the bit above the mux position.
	function automatic logic mode_of(input logic [CHAN_W-1:0] chan);
		return chan[MUX_W];
	endfunction

endpackage

>>> design/acrq_dp.sv
// Datapath of the conversion request queue: slot status, order FIFO,
// channel store and result register. Depends on acrq_pkg and the assert header.
`include "adc_conversion_request_queue_assert.svh"

module acrq_dp import acrq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	input  req_t     req,
	output rsp_t     rsp
);

	req_t              item_q;
	slot_state_t       status_q [SLOTS];
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  fifo_mem [SLOTS];
	logic [CHAN_W-1:0] chan_mem [SLOTS];
	logic [IDX_W-1:0]  fifo_rd_q;
	logic [CHAN_W-1:0] chan_rd_q;
	rsp_t              res_q;

	logic [IDX_W-1:0] slot_idx;
	logic             is_enq;
	logic             is_cmp;
	logic             enq_ok;
	logic             pop_ok;
	logic             queue_empty;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	// Decode of the held request against the queue state.
	assign slot_idx    = item_q.request_slot[IDX_W-1:0];
	assign is_enq      = cmd_t'(item_q.command) == CMD_ENQUEUE;
	assign is_cmp      = cmd_t'(item_q.command) == CMD_COMPLETE;
	assign queue_empty = count_q == '0;
	assign enq_ok      = is_enq && (int'(item_q.request_slot) < SLOTS) &&
		(status_q[slot_idx] == SLOT_IDLE) && (count_q < CNT_W'(SLOTS));
	assign pop_ok      = is_cmp && !queue_empty;
	assign stat.chain  = pop_ok && (count_q > CNT_W'(1));
	assign rsp         = res_q;

	// Request holding register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
	end

	// Slot status and FIFO pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= SLOT_IDLE;
			end
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.exec) begin
				if (enq_ok) begin
					status_q[slot_idx] <= queue_empty ? SLOT_CONVERTING : SLOT_ENQUEUED;
					tail_q  <= next_pos(tail_q);
					count_q <= count_q + 1'b1;
				end else if (pop_ok) begin
					status_q[fifo_rd_q] <= SLOT_IDLE;
					head_q  <= next_pos(head_q);
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.start) begin
				status_q[fifo_rd_q] <= SLOT_CONVERTING;
			end
		end
	end

	// Order FIFO storage; the read port always follows the head.
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			fifo_mem[tail_q] <= slot_idx;
		end
		fifo_rd_q <= fifo_mem[head_q];
	end

	// Channel store, read at the slot found at the head.
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			chan_mem[slot_idx] <= item_q.channel_code;
		end
		chan_rd_q <= chan_mem[fifo_rd_q];
	end

	// Result register: built in the execute step, start fields added later
	// when the next queued request begins its conversion.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= '0;
			if (enq_ok) begin
				res_q.enqueue_accepted <= 1'b1;
				if (queue_empty) begin
					res_q.start_conversion   <= 1'b1;
					res_q.start_mux_position <= mux_of(item_q.channel_code);
					res_q.start_input_mode   <= mode_of(item_q.channel_code);
				end
			end else if (pop_ok) begin
				res_q.done_valid <= 1'b1;
				res_q.done_slot  <= SLOT_W'(fifo_rd_q);
				res_q.done_value <= item_q.conversion_value;
			end
		end
		if (cmd.start) begin
			res_q.start_conversion   <= 1'b1;
			res_q.start_mux_position <= mux_of(chan_rd_q);
			res_q.start_input_mode   <= mode_of(chan_rd_q);
		end
	end

	// The fill count never exceeds the slot count, and an empty queue has
	// matching pointers.
	`ACRQ_ASSERT_ALWAYS(a_count_bound, clk, count_q <= CNT_W'(SLOTS))
	`ACRQ_ASSERT(a_empty_ptrs, clk, arst_n, (count_q == '0) |-> (head_q == tail_q))

endmodule

>>> design/acrq_ctrl.sv
// Controller of the conversion request queue: sequences each request
// through the datapath and runs both handshakes. Depends on acrq_pkg and the assert header.
`include "adc_conversion_request_queue_assert.svh"

module acrq_ctrl import acrq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = stat.chain ? S_FETCH : S_OUT;
			end
			// Wait for the FIFO read port to show the new head.
			S_FETCH: begin
				state_nxt = S_LOOKUP;
			end
			// Wait for the channel of that slot.
			S_LOOKUP: begin
				state_nxt = S_START;
			end
			S_START: begin
				cmd.start = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// The execute step leads either straight to the result or into the
	// lookup of the next queued request, which always ends in a start.
	`ACRQ_ASSERT(a_exec_next, clk, arst_n, (state_q == S_EXEC) |=> (state_q == S_OUT || state_q == S_FETCH))
	`ACRQ_ASSERT(a_start_next, clk, arst_n, (state_q == S_START) |=> (state_q == S_OUT))

endmodule

>>> design/adc_conversion_request_queue.sv
// A request taken in the idle state is loaded, executed and held as the result
// until accepted; when a completion starts the next queued conversion, the fetch,
// lookup and start states come before the result, set by the registered read ports
// of the FIFO and channel stores. A new request waits until the result is taken.
// Reset (arst_n low, asynchronous): all slots idle, queue empty, no result pending.
// Top level; depends on acrq_pkg, acrq_ctrl and acrq_dp.
module adc_conversion_request_queue import acrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	acrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Queue storage and result.
	acrq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
